@@ src/nlr_pkg.sv @@
`default_nettype none

package nlr_pkg;

	localparam int CHAR_W = 8;
	localparam int MASK_W = 7;

	// Bytes that have a meaning to the recognizers.
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
	localparam logic [CHAR_W-1:0] CH_O      = 8'h6F;
	localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
	localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;

	// Bit positions in the form mask.
	localparam int MB_DEC    = 0;
	localparam int MB_FLOAT  = 1;
	localparam int MB_DOLLAR = 2;
	localparam int MB_FFLT   = 3;
	localparam int MB_BFFLT  = 4;
	localparam int MB_HEX0X  = 5;
	localparam int MB_OCTBIN = 6;

	// Dialect register codes.
	localparam logic DIALECT_ASM   = 1'b0;
	localparam logic DIALECT_PLAIN = 1'b1;

	// Byte position within the token, saturating once the two prefix bytes are in.
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_BODY   = 2'd2;

	typedef struct packed {
		logic valid;
		logic empty;
		logic pending;
	} num_trk_t;

	typedef struct packed {
		logic valid;
		logic empty;
	} hex_trk_t;

	typedef struct packed {
		logic valid;
		logic empty;
		logic point;
		logic digit;
	} flt_trk_t;

	// What the top level hands the tracker block for one word.
	typedef struct packed {
		logic              fire;
		logic [CHAR_W-1:0] char_code;
	} trk_ctl_t;

	localparam num_trk_t NUM_RST = '{valid: 1'b1, empty: 1'b1, pending: 1'b0};
	localparam hex_trk_t HEX_RST = '{valid: 1'b1, empty: 1'b1};
	localparam flt_trk_t FLT_RST = '{valid: 1'b1, empty: 1'b1, point: 1'b0, digit: 1'b0};

	function automatic logic is_dec(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hexd(input logic [CHAR_W-1:0] c);
		return is_dec(c) || ((c >= CH_LO_A) && (c <= CH_F)) ||
			((c >= CH_UP_A) && (c <= CH_UP_F));
	endfunction

	function automatic num_trk_t num_feed(input num_trk_t t, input logic [CHAR_W-1:0] c);
		num_trk_t r;
		r = t;
		if (t.valid) begin
			if (t.empty && (c == CH_MINUS)) begin
				r.pending = 1'b1;
			end else if (is_dec(c)) begin
				r.pending = 1'b0;
			end else begin
				r.valid = 1'b0;
			end
		end
		r.empty = 1'b0;
		return r;
	endfunction

	function automatic hex_trk_t hex_feed(input hex_trk_t t, input logic [CHAR_W-1:0] c);
		hex_trk_t r;
		r = t;
		if (t.valid && !(t.empty && (c == CH_MINUS)) && !is_hexd(c)) begin
			r.valid = 1'b0;
		end
		r.empty = 1'b0;
		return r;
	endfunction

	function automatic flt_trk_t flt_feed(input flt_trk_t t, input logic [CHAR_W-1:0] c);
		flt_trk_t r;
		r = t;
		if (t.valid) begin
			if (t.empty && (c == CH_MINUS)) begin
				r.valid = 1'b1;
			end else if (c == CH_POINT) begin
				if (t.point) begin
					r.valid = 1'b0;
				end
				r.point = 1'b1;
			end else if (is_dec(c)) begin
				r.digit = 1'b1;
			end else begin
				r.valid = 1'b0;
			end
		end
		r.empty = 1'b0;
		return r;
	endfunction

	function automatic logic num_ok(input num_trk_t t);
		return t.valid && !t.pending;
	endfunction

	function automatic logic flt_ok(input flt_trk_t t);
		return t.valid && t.digit;
	endfunction

endpackage

`default_nettype wire

@@ src/nlr_trk.sv @@
`default_nettype none

module nlr_trk import nlr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire trk_ctl_t          ctl,
	input  wire logic              dialect,
	output logic      [MASK_W-1:0] mask
);

	logic [1:0]        pos_q;
	logic [CHAR_W-1:0] c0_q;
	logic [CHAR_W-1:0] c1_q;
	num_trk_t          num_q [2];
	hex_trk_t          hex_q [2];
	flt_trk_t          flt_q [3];
	logic              term;

	assign term = (ctl.char_code == CH_NUL);

	// Trackers for the token and for its suffixes from byte 1 and byte 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FIRST;
			c0_q  <= CH_NUL;
			c1_q  <= CH_NUL;
			for (int i = 0; i < 2; i++) begin
				num_q[i] <= NUM_RST;
				hex_q[i] <= HEX_RST;
			end
			for (int i = 0; i < 3; i++) begin
				flt_q[i] <= FLT_RST;
			end
		end else if (ctl.fire) begin
			if (term) begin
				pos_q <= POS_FIRST;
				c0_q  <= CH_NUL;
				c1_q  <= CH_NUL;
				for (int i = 0; i < 2; i++) begin
					num_q[i] <= NUM_RST;
					hex_q[i] <= HEX_RST;
				end
				for (int i = 0; i < 3; i++) begin
					flt_q[i] <= FLT_RST;
				end
			end else begin
				if (pos_q == POS_FIRST) begin
					c0_q <= ctl.char_code;
				end
				if (pos_q == POS_SECOND) begin
					c1_q <= ctl.char_code;
				end
				num_q[0] <= num_feed(num_q[0], ctl.char_code);
				flt_q[0] <= flt_feed(flt_q[0], ctl.char_code);
				if (pos_q != POS_FIRST) begin
					hex_q[0] <= hex_feed(hex_q[0], ctl.char_code);
					flt_q[1] <= flt_feed(flt_q[1], ctl.char_code);
				end
				if (pos_q == POS_BODY) begin
					num_q[1] <= num_feed(num_q[1], ctl.char_code);
					hex_q[1] <= hex_feed(hex_q[1], ctl.char_code);
					flt_q[2] <= flt_feed(flt_q[2], ctl.char_code);
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	always_comb begin
		mask = '0;
		mask[MB_DEC]    = num_ok(num_q[0]);
		mask[MB_FLOAT]  = (dialect == DIALECT_PLAIN) && flt_ok(flt_q[0]);
		mask[MB_DOLLAR] = (dialect == DIALECT_ASM) && (c0_q == CH_DOLLAR) && hex_q[0].valid;
		mask[MB_FFLT]   = (c0_q == CH_F) && flt_ok(flt_q[1]);
		mask[MB_BFFLT]  = (dialect == DIALECT_ASM) && (c0_q == CH_B) && (c1_q == CH_F) &&
			flt_ok(flt_q[2]);
		mask[MB_HEX0X]  = (c0_q == CH_ZERO) && (c1_q == CH_X) && hex_q[1].valid;
		mask[MB_OCTBIN] = (c0_q == CH_ZERO) && ((c1_q == CH_O) || (c1_q == CH_B)) &&
			num_ok(num_q[1]);
	end

endmodule

`default_nettype wire

@@ src/numeric_literal_recognizer.sv @@
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  char_code[7:0]
// result    out        out_valid/ out_stall is_immediate, form_mask[6:0]
// config    in         cfg_we               cfg_wdata (dialect)
//
// An accepted word sits in the input register until it advances; then it updates
// the trackers, and a terminating zero byte loads the result register at that same edge,
// so its result is offered once the terminator has left the input register.
// One word is accepted per cycle while the input is not stalled; the tracker update is the only state loop.
// Reset (arst_n low) clears the trackers, the dialect (assembler rules) and all valids.
// A stalled result holds the input register only when it carries a terminator;
// ordinary token bytes keep flowing into the trackers while a result waits.

module numeric_literal_recognizer import nlr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CHAR_W-1:0] char_code,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   is_immediate,
	output logic      [MASK_W-1:0] form_mask
);

	logic              dialect_q;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              out_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic              term_s1;
	logic              adv_s1;
	logic              in_acc;
	trk_ctl_t          ctl;
	logic [MASK_W-1:0] mask;

	// Dialect register; write it only while no word is in flight (the block does not enforce this).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dialect_q <= DIALECT_ASM;
		end else if (cfg_we) begin
			dialect_q <= cfg_wdata;
		end
	end

	// A terminator needs a free result register to move on; any other byte
	// only updates tracker bits and never waits.
	assign term_s1  = (char_s1 == CH_NUL);
	assign adv_s1   = valid_s1 && (!term_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= char_code;
		end
	end

	assign ctl.fire      = adv_s1;
	assign ctl.char_code = char_s1;

	nlr_trk u_trk (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.dialect (dialect_q),
		.mask    (mask)
	);

	// Result register: loaded when a terminator leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && term_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && term_s1) begin
			mask_q <= mask;
		end
	end

	assign out_valid    = out_valid_q;
	assign form_mask    = mask_q;
	assign is_immediate = (mask_q != '0);

endmodule

`default_nettype wire

@@ src/nlr_chk.sv @@
`default_nettype none

module nlr_chk import nlr_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              is_immediate,
	input wire logic [MASK_W-1:0] form_mask
);

	// A stalled result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(form_mask) && $stable(is_immediate))
		else $error("result word changed while stalled");

	// The input only backs up behind a result that is itself stalled.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// The flag agrees with the mask.
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_immediate == (form_mask != '0)))
		else $error("is_immediate disagrees with form_mask");

	// Bare float belongs to the plain dialect, dollar and bf forms to the assembler one.
	a_dialect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(form_mask[MB_FLOAT] && (form_mask[MB_DOLLAR] || form_mask[MB_BFFLT])))
		else $error("forms of both dialects reported together");

	// A 0x prefix rules out plain decimal and the 0o/0b forms.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(form_mask[MB_HEX0X] && (form_mask[MB_DEC] || form_mask[MB_OCTBIN])))
		else $error("0x hex reported with a conflicting form");

endmodule

bind numeric_literal_recognizer nlr_chk u_nlr_chk (.*);

`default_nettype wire
